// ----- hdl/tfs_pkg.sv -----
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types and codes of the two-level feedback scheduler: beat payloads,
// process table entry, outcome, command, queue and register codes.
// ----------------------------------------------------------------------------
package tfs_pkg;

	typedef struct packed {
		logic        command;
		logic [15:0] proc_id;
		logic [15:0] arrival_time;
		logic [15:0] service_time;
		logic [1:0]  io_kind;
		logic [15:0] io_at;
	} in_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [15:0] run_id;
		logic [7:0]  ticks_used;
		logic [31:0] clock_now;
		logic [4:0]  finished_total;
	} out_t;

	typedef struct packed {
		logic [15:0] pid;
		logic [15:0] arrival;
		logic [15:0] service;
		logic [15:0] executed;
		logic [1:0]  io_kind;
		logic [15:0] io_at;
		logic [15:0] io_left;
	} entry_t;

	localparam logic CMD_ADMIT = 1'b0;
	localparam logic CMD_ROUND = 1'b1;

	localparam logic [2:0] OUT_ADMITTED  = 3'd0;
	localparam logic [2:0] OUT_IDLE      = 3'd1;
	localparam logic [2:0] OUT_FINISHED  = 3'd2;
	localparam logic [2:0] OUT_IO        = 3'd3;
	localparam logic [2:0] OUT_PREEMPTED = 3'd4;
	localparam logic [2:0] OUT_ALL_DONE  = 3'd5;
	localparam logic [2:0] OUT_FULL      = 3'd6;

	localparam logic [2:0] Q_HIGH    = 3'd0;
	localparam logic [2:0] Q_LOW     = 3'd1;
	localparam logic [2:0] Q_DISK    = 3'd2;
	localparam logic [2:0] Q_TAPE    = 3'd3;
	localparam logic [2:0] Q_PRINTER = 3'd4;
	localparam int NUM_QUEUES = 5;

	localparam logic [1:0] IO_NONE    = 2'd0;
	localparam logic [1:0] IO_DISK    = 2'd1;
	localparam logic [1:0] IO_TAPE    = 2'd2;
	localparam logic [1:0] IO_PRINTER = 2'd3;

	localparam logic [2:0] REG_PROCESS_COUNT = 3'd0;
	localparam logic [2:0] REG_QUANTUM       = 3'd1;
	localparam logic [2:0] REG_DISK_DUR      = 3'd2;
	localparam logic [2:0] REG_TAPE_DUR      = 3'd3;
	localparam logic [2:0] REG_PRINTER_DUR   = 3'd4;

endpackage

// ----- hdl/tfs_ram.sv -----
// ----------------------------------------------------------------------------
// tfs_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module tfs_ram #(
	parameter int DEPTH = 16,
	parameter int AW = 4,
	parameter int W = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/two_level_feedback_scheduler.sv -----
// ----------------------------------------------------------------------------
// two_level_feedback_scheduler
// Admit writes the table entry unless the table is full and returns a result.
// Round: an arrival scan over the admitted slots, an aging pass over each I/O queue
// and its waiting entries, then a run of up to quantum ticks (one tick per cycle,
// preemption seen in the cycle after the last tick); one beat at a time.
// Reset: asynchronous, clears control state, counters, queues and arrived bits.
// ----------------------------------------------------------------------------
module two_level_feedback_scheduler #(
	parameter int MAX_PROCS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tfs_pkg::in_t     in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output tfs_pkg::out_t    out_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW  = $clog2(MAX_PROCS + 1);
	localparam int SW  = CW + 1;
	localparam int FW  = (CW > 5) ? CW : 5;
	localparam int QD  = tfs_pkg::NUM_QUEUES * MAX_PROCS;
	localparam int QAW = $clog2(QD);
	localparam int EW  = $bits(tfs_pkg::entry_t);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCAN_RD = 4'd1;
	localparam logic [3:0] S_SCAN_EV = 4'd2;
	localparam logic [3:0] S_AGE_ST  = 4'd3;
	localparam logic [3:0] S_AGE_RQ  = 4'd4;
	localparam logic [3:0] S_AGE_RT  = 4'd5;
	localparam logic [3:0] S_AGE_EV  = 4'd6;
	localparam logic [3:0] S_PICK    = 4'd7;
	localparam logic [3:0] S_PICK_RT = 4'd8;
	localparam logic [3:0] S_RUN_LD  = 4'd9;
	localparam logic [3:0] S_RUN     = 4'd10;
	localparam logic [3:0] S_WB      = 4'd11;
	localparam logic [3:0] S_DONE    = 4'd12;

	function automatic logic [QAW-1:0] qaddr(input logic [2:0] q, input logic [IW-1:0] idx);
		return QAW'(int'(q) * MAX_PROCS) + QAW'(idx);
	endfunction

	function automatic logic [IW-1:0] tail(input logic [IW-1:0] h, input logic [CW-1:0] c);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(c);
		if (s >= SW'(MAX_PROCS)) begin
			s = s - SW'(MAX_PROCS);
		end
		return s[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] h);
		return (h == IW'(MAX_PROCS - 1)) ? '0 : IW'(h + 1'b1);
	endfunction

	// configuration
	logic [4:0]  pcount_q;
	logic [7:0]  quantum_q;
	logic [15:0] disk_dur_q, tape_dur_q, prn_dur_q;

	// scheduler state
	logic [3:0]           state_q;
	logic [31:0]          clock_q;
	logic [CW-1:0]        fin_q;
	logic [CW-1:0]        adm_q;
	logic [MAX_PROCS-1:0] arrived_q;
	logic [IW-1:0]        head_q [tfs_pkg::NUM_QUEUES];
	logic [CW-1:0]        cnt_q  [tfs_pkg::NUM_QUEUES];

	logic [CW-1:0]  scan_q;
	logic [2:0]     aq_q;
	logic [CW-1:0]  an_q;
	logic [IW-1:0]  slot_q;
	tfs_pkg::entry_t ent_q;
	logic [7:0]     ticks_q;
	logic [2:0]     outc_q;
	logic [15:0]    rid_q;
	logic           push_pend_q;
	logic [2:0]     push_sel_q;

	logic out_valid_q;
	tfs_pkg::out_t out_q;

	// memory ports
	logic            t_we;
	logic [IW-1:0]   t_waddr, t_raddr;
	tfs_pkg::entry_t t_wdata, t_rd;
	logic [EW-1:0]   t_rdata;
	logic            q_we;
	logic [QAW-1:0]  q_waddr, q_raddr;
	logic [IW-1:0]   q_wdata, q_rdata;

	logic           push_en, pop_en;
	logic [2:0]     push_sel, pop_sel, rq_sel, pick_q;
	logic           acc, free_out, round_done;
	logic [15:0]    ex_n;
	tfs_pkg::entry_t age_n;
	logic           age_fin;

	assign t_rd       = tfs_pkg::entry_t'(t_rdata);
	assign acc        = in_valid && (state_q == S_IDLE);
	assign in_ready   = (state_q == S_IDLE);
	assign free_out   = !out_valid_q || out_ready;
	assign round_done = FW'(fin_q) >= FW'(pcount_q);
	assign pick_q     = (cnt_q[tfs_pkg::Q_HIGH] != '0) ? tfs_pkg::Q_HIGH : tfs_pkg::Q_LOW;
	assign ex_n       = ent_q.executed + 16'd1;
	assign age_fin    = (t_rd.io_left <= 16'd1);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_comb begin
		age_n = t_rd;
		if (age_fin) begin
			age_n.io_left = '0;
			age_n.io_kind = tfs_pkg::IO_NONE;
		end else begin
			age_n.io_left = t_rd.io_left - 16'd1;
		end
	end

	always_comb begin
		t_we     = 1'b0;
		t_waddr  = slot_q;
		t_wdata  = ent_q;
		t_raddr  = scan_q[IW-1:0];
		push_en  = 1'b0;
		push_sel = tfs_pkg::Q_HIGH;
		q_wdata  = slot_q;
		pop_en   = 1'b0;
		pop_sel  = aq_q;
		rq_sel   = aq_q;
		unique case (state_q)
			S_IDLE: begin
				t_waddr = adm_q[IW-1:0];
				t_wdata.pid      = in_data.proc_id;
				t_wdata.arrival  = in_data.arrival_time;
				t_wdata.service  = in_data.service_time;
				t_wdata.executed = '0;
				t_wdata.io_kind  = in_data.io_kind;
				t_wdata.io_at    = in_data.io_at;
				t_wdata.io_left  = '0;
				t_we = acc && (in_data.command == tfs_pkg::CMD_ADMIT)
					&& (adm_q < CW'(MAX_PROCS));
			end
			S_SCAN_EV: begin
				q_wdata = scan_q[IW-1:0];
				push_en = !arrived_q[scan_q[IW-1:0]]
					&& ({16'd0, t_rd.arrival} <= clock_q);
			end
			S_AGE_RT: begin
				t_raddr = q_rdata;
			end
			S_AGE_EV: begin
				t_we     = 1'b1;
				t_wdata  = age_n;
				pop_en   = 1'b1;
				push_en  = 1'b1;
				push_sel = !age_fin ? aq_q
					: ((aq_q == tfs_pkg::Q_DISK) ? tfs_pkg::Q_LOW : tfs_pkg::Q_HIGH);
			end
			S_PICK: begin
				rq_sel  = pick_q;
				pop_sel = pick_q;
				pop_en  = (cnt_q[tfs_pkg::Q_HIGH] != '0) || (cnt_q[tfs_pkg::Q_LOW] != '0);
			end
			S_PICK_RT: begin
				t_raddr = q_rdata;
			end
			S_WB: begin
				t_we     = 1'b1;
				push_en  = push_pend_q;
				push_sel = push_sel_q;
			end
			default: begin
			end
		endcase
	end

	assign q_we    = push_en;
	assign q_waddr = qaddr(push_sel, tail(head_q[push_sel], cnt_q[push_sel]));
	assign q_raddr = qaddr(rq_sel, head_q[rq_sel]);

	tfs_ram #(.DEPTH(MAX_PROCS), .AW(IW), .W(EW)) u_table (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (EW'(t_wdata)),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	tfs_ram #(.DEPTH(QD), .AW(QAW), .W(IW)) u_queues (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// queue heads and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < tfs_pkg::NUM_QUEUES; g++) begin
				head_q[g] <= '0;
				cnt_q[g]  <= '0;
			end
		end else begin
			for (int g = 0; g < tfs_pkg::NUM_QUEUES; g++) begin
				if (pop_en && pop_sel == 3'(g)) begin
					head_q[g] <= inc_wrap(head_q[g]);
				end
				if ((push_en && push_sel == 3'(g)) && !(pop_en && pop_sel == 3'(g))) begin
					cnt_q[g] <= cnt_q[g] + 1'b1;
				end else if (!(push_en && push_sel == 3'(g)) && (pop_en && pop_sel == 3'(g))) begin
					cnt_q[g] <= cnt_q[g] - 1'b1;
				end
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q   <= 5'd0;
			quantum_q  <= 8'd2;
			disk_dur_q <= 16'd3;
			tape_dur_q <= 16'd5;
			prn_dur_q  <= 16'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfs_pkg::REG_PROCESS_COUNT: pcount_q   <= cfg_data[4:0];
				tfs_pkg::REG_QUANTUM:       quantum_q  <= cfg_data[7:0];
				tfs_pkg::REG_DISK_DUR:      disk_dur_q <= cfg_data;
				tfs_pkg::REG_TAPE_DUR:      tape_dur_q <= cfg_data;
				tfs_pkg::REG_PRINTER_DUR:   prn_dur_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// payload work registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rid_q       <= '0;
				ticks_q     <= '0;
				scan_q      <= '0;
				aq_q        <= tfs_pkg::Q_DISK;
				push_pend_q <= 1'b0;
				if (in_data.command == tfs_pkg::CMD_ADMIT) begin
					outc_q <= (adm_q < CW'(MAX_PROCS)) ? tfs_pkg::OUT_ADMITTED
						: tfs_pkg::OUT_FULL;
				end else begin
					outc_q <= tfs_pkg::OUT_ALL_DONE;
				end
			end
			S_SCAN_EV: scan_q <= scan_q + 1'b1;
			S_AGE_ST: an_q <= cnt_q[aq_q];
			S_AGE_RT: slot_q <= q_rdata;
			S_AGE_EV: begin
				an_q <= an_q - 1'b1;
				if (an_q == CW'(1)) begin
					aq_q <= aq_q + 3'd1;
				end
			end
			S_PICK: outc_q <= tfs_pkg::OUT_IDLE;
			S_PICK_RT: slot_q <= q_rdata;
			S_RUN_LD: begin
				ent_q <= t_rd;
				rid_q <= t_rd.pid;
			end
			S_RUN: begin
				if (ticks_q < quantum_q) begin
					ent_q.executed <= ex_n;
					ticks_q <= ticks_q + 8'd1;
					if (ex_n >= ent_q.service) begin
						outc_q <= tfs_pkg::OUT_FINISHED;
					end else if (ent_q.io_kind != tfs_pkg::IO_NONE && ex_n == ent_q.io_at) begin
						outc_q      <= tfs_pkg::OUT_IO;
						push_pend_q <= 1'b1;
						push_sel_q  <= 3'(ent_q.io_kind) + 3'd1;
						case (ent_q.io_kind)
							tfs_pkg::IO_DISK: ent_q.io_left <= disk_dur_q;
							tfs_pkg::IO_TAPE: ent_q.io_left <= tape_dur_q;
							default:          ent_q.io_left <= prn_dur_q;
						endcase
					end
				end else begin
					outc_q      <= tfs_pkg::OUT_PREEMPTED;
					push_pend_q <= 1'b1;
					push_sel_q  <= tfs_pkg::Q_LOW;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_AGE_ST && cnt_q[aq_q] == '0) begin
			aq_q <= aq_q + 3'd1;
		end
		if (state_q == S_DONE && free_out) begin
			out_q.outcome        <= outc_q;
			out_q.run_id         <= rid_q;
			out_q.ticks_used     <= ticks_q;
			out_q.clock_now      <= clock_q;
			out_q.finished_total <= 5'(fin_q);
		end
	end

	// control state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clock_q     <= '0;
			fin_q       <= '0;
			adm_q       <= '0;
			arrived_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && free_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (in_data.command == tfs_pkg::CMD_ADMIT) begin
							if (adm_q < CW'(MAX_PROCS)) begin
								adm_q <= adm_q + 1'b1;
								arrived_q[adm_q[IW-1:0]] <= 1'b0;
							end
							state_q <= S_DONE;
						end else if (round_done) begin
							state_q <= S_DONE;
						end else if (adm_q == '0) begin
							state_q <= S_AGE_ST;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					if (push_en) begin
						arrived_q[scan_q[IW-1:0]] <= 1'b1;
					end
					state_q <= (scan_q + 1'b1 == adm_q) ? S_AGE_ST : S_SCAN_RD;
				end
				S_AGE_ST: begin
					if (cnt_q[aq_q] != '0) begin
						state_q <= S_AGE_RQ;
					end else if (aq_q == tfs_pkg::Q_PRINTER) begin
						state_q <= S_PICK;
					end
				end
				S_AGE_RQ: state_q <= S_AGE_RT;
				S_AGE_RT: state_q <= S_AGE_EV;
				S_AGE_EV: begin
					if (an_q != CW'(1)) begin
						state_q <= S_AGE_RQ;
					end else if (aq_q == tfs_pkg::Q_PRINTER) begin
						state_q <= S_PICK;
					end else begin
						state_q <= S_AGE_ST;
					end
				end
				S_PICK: begin
					if (pop_en) begin
						state_q <= S_PICK_RT;
					end else begin
						clock_q <= clock_q + 32'd1;
						state_q <= S_DONE;
					end
				end
				S_PICK_RT: state_q <= S_RUN_LD;
				S_RUN_LD:  state_q <= S_RUN;
				S_RUN: begin
					if (ticks_q < quantum_q) begin
						clock_q <= clock_q + 32'd1;
						if (ex_n >= ent_q.service) begin
							fin_q   <= fin_q + 1'b1;
							state_q <= S_WB;
						end else if (ent_q.io_kind != tfs_pkg::IO_NONE && ex_n == ent_q.io_at) begin
							state_q <= S_WB;
						end
					end else begin
						state_q <= S_WB;
					end
				end
				S_WB: state_q <= S_DONE;
				S_DONE: begin
					if (free_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- bench/two_level_feedback_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_feedback_scheduler_tb
// Drives admit and round beats through the scheduler with bursty input and
// stalled output. A scoreboard class keeps its own process table, queues and
// clock, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module two_level_feedback_scheduler_tb;

	localparam int NPROC = 16;

	class sched_scoreboard;
		logic [4:0]  proc_goal;
		logic [7:0]  quantum;
		logic [15:0] dur[3];
		logic [31:0] clk_cnt;
		int          done_cnt;
		int          admit_cnt;
		tfs_pkg::entry_t tbl[NPROC];
		bit          arrived[NPROC];
		int          q[tfs_pkg::NUM_QUEUES][$];
		tfs_pkg::out_t pending[$];
		int          errors;

		function void clear();
			proc_goal = 5'd0;
			quantum = 8'd2;
			dur[0] = 16'd3;
			dur[1] = 16'd5;
			dur[2] = 16'd7;
			clk_cnt = 32'd0;
			done_cnt = 0;
			admit_cnt = 0;
			errors = 0;
			pending.delete();
			for (int i = 0; i < NPROC; i++) begin
				arrived[i] = 1'b0;
				tbl[i] = '0;
			end
			for (int i = 0; i < tfs_pkg::NUM_QUEUES; i++)
				q[i].delete();
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] v);
			case (idx)
				tfs_pkg::REG_PROCESS_COUNT: proc_goal = v[4:0];
				tfs_pkg::REG_QUANTUM:       quantum = v[7:0];
				tfs_pkg::REG_DISK_DUR:      dur[0] = v;
				tfs_pkg::REG_TAPE_DUR:      dur[1] = v;
				tfs_pkg::REG_PRINTER_DUR:   dur[2] = v;
				default: ;
			endcase
		endfunction

		function void age(int src, int dst);
			int n;
			int s;
			n = q[src].size();
			for (int i = 0; i < n; i++) begin
				s = q[src].pop_front();
				if (tbl[s].io_left <= 16'd1) begin
					tbl[s].io_left = 16'd0;
					tbl[s].io_kind = tfs_pkg::IO_NONE;
					q[dst].push_back(s);
				end else begin
					tbl[s].io_left--;
					q[src].push_back(s);
				end
			end
		endfunction

		function void note_beat(tfs_pkg::in_t b);
			tfs_pkg::out_t r;
			int s;
			int k;
			r = '0;
			if (b.command == tfs_pkg::CMD_ADMIT) begin
				if (admit_cnt >= NPROC) begin
					r.outcome = tfs_pkg::OUT_FULL;
				end else begin
					s = admit_cnt;
					tbl[s].pid = b.proc_id;
					tbl[s].arrival = b.arrival_time;
					tbl[s].service = b.service_time;
					tbl[s].io_kind = b.io_kind;
					tbl[s].io_at = b.io_at;
					tbl[s].io_left = 16'd0;
					tbl[s].executed = 16'd0;
					arrived[s] = 1'b0;
					admit_cnt++;
					r.outcome = tfs_pkg::OUT_ADMITTED;
				end
			end else if (done_cnt >= int'(proc_goal)) begin
				r.outcome = tfs_pkg::OUT_ALL_DONE;
			end else begin
				for (int i = 0; i < admit_cnt; i++)
					if (!arrived[i] && {16'd0, tbl[i].arrival} <= clk_cnt) begin
						arrived[i] = 1'b1;
						q[tfs_pkg::Q_HIGH].push_back(i);
					end
				age(tfs_pkg::Q_DISK, tfs_pkg::Q_LOW);
				age(tfs_pkg::Q_TAPE, tfs_pkg::Q_HIGH);
				age(tfs_pkg::Q_PRINTER, tfs_pkg::Q_HIGH);
				if (q[tfs_pkg::Q_HIGH].size() == 0 && q[tfs_pkg::Q_LOW].size() == 0) begin
					clk_cnt++;
					r.outcome = tfs_pkg::OUT_IDLE;
				end else begin
					s = q[tfs_pkg::Q_HIGH].size() ? q[tfs_pkg::Q_HIGH].pop_front()
						: q[tfs_pkg::Q_LOW].pop_front();
					r.run_id = tbl[s].pid;
					r.outcome = tfs_pkg::OUT_PREEMPTED;
					while (r.ticks_used < quantum) begin
						tbl[s].executed++;
						r.ticks_used++;
						clk_cnt++;
						if (tbl[s].executed >= tbl[s].service) begin
							done_cnt++;
							r.outcome = tfs_pkg::OUT_FINISHED;
							break;
						end
						if (tbl[s].io_kind != tfs_pkg::IO_NONE
								&& tbl[s].executed == tbl[s].io_at) begin
							k = int'(tbl[s].io_kind);
							tbl[s].io_left = dur[k-1];
							q[tfs_pkg::Q_DISK + k - 1].push_back(s);
							r.outcome = tfs_pkg::OUT_IO;
							break;
						end
					end
					if (r.outcome == tfs_pkg::OUT_PREEMPTED)
						q[tfs_pkg::Q_LOW].push_back(s);
				end
			end
			r.clock_now = clk_cnt;
			r.finished_total = done_cnt[4:0];
			pending.push_back(r);
		endfunction

		function void check_beat(tfs_pkg::out_t got);
			tfs_pkg::out_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result %p", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.outcome !== e.outcome) begin
				$display("%0t outcome exp %0d got %0d", $time, e.outcome, got.outcome);
				errors++;
			end
			if (got.run_id !== e.run_id) begin
				$display("%0t run_id exp %h got %h", $time, e.run_id, got.run_id);
				errors++;
			end
			if (got.ticks_used !== e.ticks_used) begin
				$display("%0t ticks_used exp %0d got %0d", $time, e.ticks_used, got.ticks_used);
				errors++;
			end
			if (got.clock_now !== e.clock_now) begin
				$display("%0t clock_now exp %0d got %0d", $time, e.clock_now, got.clock_now);
				errors++;
			end
			if (got.finished_total !== e.finished_total) begin
				$display("%0t finished_total exp %0d got %0d", $time, e.finished_total,
					got.finished_total);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	tfs_pkg::in_t in_data;
	logic        out_valid;
	logic        out_ready;
	tfs_pkg::out_t out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	sched_scoreboard sb;
	int          idle_cycles;
	int          burst_left;
	int          stall_mode;

	two_level_feedback_scheduler uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result side and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_beat(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 200000) begin
				$display("two_level_feedback_scheduler_tb failed");
				$finish;
			end
		end
	end

	// receiver stall pattern, mode changes now and then
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 3) != 0;
			2: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= $urandom_range(0, 7) == 0;
		endcase
	end

	task automatic send_beat(tfs_pkg::in_t b);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_data <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(b);
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic admit(logic [15:0] pid, logic [15:0] arr, logic [15:0] svc,
			logic [1:0] kind, logic [15:0] at);
		tfs_pkg::in_t b;
		b.command = tfs_pkg::CMD_ADMIT;
		b.proc_id = pid;
		b.arrival_time = arr;
		b.service_time = svc;
		b.io_kind = kind;
		b.io_at = at;
		send_beat(b);
	endtask

	task automatic round();
		tfs_pkg::in_t b;
		b = tfs_pkg::in_t'($bits(tfs_pkg::in_t)'({$urandom, $urandom, $urandom}));
		b.command = tfs_pkg::CMD_ROUND;
		send_beat(b);
	endtask

	initial begin
		int sent;
		int nproc;
		logic [15:0] svc;
		logic [15:0] arr;
		sb = new();
		sb.clear();
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = tfs_pkg::REG_PROCESS_COUNT;
		cfg_data = 0;
		out_ready = 0;
		stall_mode = 0;
		burst_left = 0;
		idle_cycles = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: defaults, extremes, zero service, io at tick zero, table full
		round();
		admit(16'hFFFF, 16'd0, 16'd0, tfs_pkg::IO_DISK, 16'd0);
		admit(16'h0000, 16'd0, 16'd3, tfs_pkg::IO_DISK, 16'd1);
		admit(16'h1234, 16'd2, 16'd4, tfs_pkg::IO_TAPE, 16'd2);
		admit(16'hA5A5, 16'd1, 16'd2, tfs_pkg::IO_PRINTER, 16'd1);
		admit(16'h5A5A, 16'hFFFF, 16'hFFFF, tfs_pkg::IO_NONE, 16'hFFFF);
		drain();
		write_reg(tfs_pkg::REG_PROCESS_COUNT, 16'd4);
		repeat (14) round();
		drain();
		write_reg(tfs_pkg::REG_QUANTUM, 16'd0);
		write_reg(tfs_pkg::REG_PROCESS_COUNT, 16'd5);
		repeat (2) round();
		drain();
		write_reg(tfs_pkg::REG_QUANTUM, 16'd255);
		write_reg(tfs_pkg::REG_DISK_DUR, 16'd0);
		write_reg(tfs_pkg::REG_TAPE_DUR, 16'hFFFF);
		write_reg(tfs_pkg::REG_PRINTER_DUR, 16'd1);
		for (int i = 0; i < 12; i++)
			admit(16'(i), 16'd0, 16'd1, tfs_pkg::IO_NONE, 16'd0);
		round();
		drain();
		sent = 0;

		// random phases, each a fresh process set after a reset of counters is
		// impossible, so later phases mostly exercise table full and idle/done
		while (sent < 1400) begin
			drain();
			write_reg(tfs_pkg::REG_QUANTUM,
				16'($urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 6)));
			write_reg(tfs_pkg::REG_DISK_DUR, 16'($urandom_range(0, 4)));
			write_reg(tfs_pkg::REG_TAPE_DUR, 16'($urandom_range(0, 4)));
			write_reg(tfs_pkg::REG_PRINTER_DUR, 16'($urandom_range(0, 4)));
			write_reg(tfs_pkg::REG_PROCESS_COUNT, 16'($urandom_range(0, 31)));
			nproc = $urandom_range(0, 3);
			for (int i = 0; i < nproc; i++) begin
				svc = 16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 12));
				arr = $urandom_range(0, 3) == 0 ? 16'($urandom)
					: sb.clk_cnt[15:0] + 16'($urandom_range(0, 8));
				admit(16'($urandom), arr, svc, 2'($urandom),
					16'($urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 10)));
				sent++;
			end
			for (int i = 0; i < 40; i++) begin
				round();
				sent++;
			end
		end
		drain();
		write_reg(tfs_pkg::REG_PROCESS_COUNT, 16'd16);
		write_reg(tfs_pkg::REG_PROCESS_COUNT, 16'd0);
		round();
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("two_level_feedback_scheduler_tb passed");
		else
			$display("two_level_feedback_scheduler_tb failed");
		$finish;
	end
endmodule
